// ===== hdl/dewf_pkg.sv =====
// Shared types, constants and table helper for the directional edge weight filter.
package dewf_pkg;

    localparam int MAX_WIDTH         = 2048;
    localparam int EXP_TABLE_ENTRIES = 256;
    localparam int X_W               = $clog2(MAX_WIDTH);
    localparam int W_W               = $clog2(MAX_WIDTH + 1);
    localparam int IDX_W             = $clog2(EXP_TABLE_ENTRIES);
    localparam int TAB_W             = $clog2(EXP_TABLE_ENTRIES + 1);
    localparam int FLUSH_W           = 12;
    localparam int FLUSH_MAX         = (1 << FLUSH_W) - 1;
    localparam int FIFO_DEPTH        = 4;
    localparam int FIFO_AW           = $clog2(FIFO_DEPTH);
    localparam int DIFF_W            = 19;
    localparam int P_W               = 36;
    localparam int PC_W              = 13;
    localparam int U_W               = 39;

    localparam longint LOG2E_Q24     = 24204406;
    localparam longint LN2_Q30       = 744261118;
    // -d*inv_gamma at or above SAT_P gives log2(weight) >= 12; at or below ZERO_P
    // it gives log2(weight) < -14.
    localparam longint SAT_P         = 2130;
    localparam longint ZERO_P        = -2485;
    localparam longint U_OFFSET      = 64'd14 << 32;

    localparam logic [1:0]  DIRECTION_RESET   = 2'd0;
    localparam logic [15:0] INV_GAMMA_RESET   = 16'd256;
    localparam logic [11:0] IMAGE_WIDTH_RESET = 12'd640;

    typedef enum logic [1:0] {
        REG_DIRECTION   = 2'd0,
        REG_INV_GAMMA   = 2'd1,
        REG_IMAGE_WIDTH = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        DIR_HORIZONTAL = 2'd0,
        DIR_VERTICAL   = 2'd1,
        DIR_MAIN_DIAG  = 2'd2,
        DIR_ANTI_DIAG  = 2'd3
    } direction_t;

    typedef struct packed {
        logic [15:0] pixel;
        logic        flush;
    } in_beat_t;

    typedef struct packed {
        logic [23:0] weight;
        logic        end_of_row;
        logic        end_of_frame;
    } out_beat_t;

    // One classified item handed from the front to the back.
    typedef struct packed {
        logic [15:0]    pixel;
        logic           flush;
        logic [X_W-1:0] x;
        logic [1:0]     row_phase;
        logic           emit_wrap;
        logic           emit_main;
        logic           w_one;
        logic           x_one;
        logic           last_flush;
    } item_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] d;
        logic                     end_of_row;
        logic                     end_of_frame;
    } diff_t;

    // Truncated Taylor series of 2^(i/EXP_TABLE_ENTRIES) in Q2.30.
    function automatic logic [31:0] pow2_raw(input int i);
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] s;
        x = (64'(i) * 64'(LN2_Q30)) / 64'(EXP_TABLE_ENTRIES);
        t = 64'd1 << 30;
        s = t;
        t = (t * x) >> 30;          s = s + t;
        t = ((t * x) >> 30) / 2;    s = s + t;
        t = ((t * x) >> 30) / 3;    s = s + t;
        t = ((t * x) >> 30) / 4;    s = s + t;
        t = ((t * x) >> 30) / 5;    s = s + t;
        t = ((t * x) >> 30) / 6;    s = s + t;
        t = ((t * x) >> 30) / 7;    s = s + t;
        t = ((t * x) >> 30) / 8;    s = s + t;
        t = ((t * x) >> 30) / 9;    s = s + t;
        t = ((t * x) >> 30) / 10;   s = s + t;
        t = ((t * x) >> 30) / 11;   s = s + t;
        t = ((t * x) >> 30) / 12;   s = s + t;
        t = ((t * x) >> 30) / 13;   s = s + t;
        t = ((t * x) >> 30) / 14;   s = s + t;
        t = ((t * x) >> 30) / 15;   s = s + t;
        t = ((t * x) >> 30) / 16;   s = s + t;
        t = ((t * x) >> 30) / 17;   s = s + t;
        t = ((t * x) >> 30) / 18;   s = s + t;
        t = ((t * x) >> 30) / 19;   s = s + t;
        t = ((t * x) >> 30) / 20;   s = s + t;
        return s[31:0];
    endfunction

endpackage

// ===== hdl/directional_edge_weight_filter.sv =====
// Top level of the directional edge weight filter.
//
// Pixels enter in raster order on the in_valid/in_stall channel, one beat per
// clock, with flush set on the image_width+1 padding beats that close a frame.
// For each pixel the block forms the second difference along the configured
// direction (edges clamped) and returns exp(-d*inv_gamma) as Q12.12 on the
// out_valid/out_stall channel, saturated at 0xFFFFFF and flushed to zero.
// A pixel's weight becomes due once the beat one row plus one pixel later is
// taken; it then passes the queue, the window stage and the exp stages.
// Throughput is one beat per clock while nothing stalls: the line buffers take
// one read and one write per cycle, and the exp pipeline is fully staged.
// A four-entry queue parts the counting front end from the buffer and exp
// back end, so input beats keep flowing while a result waits for the receiver.
// When out_stall holds a valid beat, the back end freezes, the queue fills and
// in_stall rises once it is full.
// Reset clears counters, window, queue and pipeline and loads the register
// defaults (horizontal, inv_gamma 1.0, width 640). Line buffers are not
// cleared; the first row of a frame never reads them.
// Write configuration through cfg_write/cfg_index/cfg_data only while idle.
module directional_edge_weight_filter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dewf_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output dewf_pkg::out_beat_t out_data,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    logic [1:0]  direction_reg;
    logic [15:0] inv_gamma_reg;
    logic [11:0] image_width_reg;

    logic            in_accept;
    logic            adv;
    logic            fifo_full, fifo_not_empty, fifo_pop;
    dewf_pkg::item_t front_item, fifo_item;
    logic            diff_valid;
    dewf_pkg::diff_t diff;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = fifo_full;
    // Advance the back end unless a finished beat is held by the receiver.
    assign adv       = !(out_valid && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg   <= dewf_pkg::DIRECTION_RESET;
            inv_gamma_reg   <= dewf_pkg::INV_GAMMA_RESET;
            image_width_reg <= dewf_pkg::IMAGE_WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            case (dewf_pkg::reg_index_t'(cfg_index))
                dewf_pkg::REG_DIRECTION:   direction_reg   <= cfg_data[1:0];
                dewf_pkg::REG_INV_GAMMA:   inv_gamma_reg   <= cfg_data;
                dewf_pkg::REG_IMAGE_WIDTH: image_width_reg <= cfg_data[11:0];
                default:                   ;
            endcase
        end
    end

    dewf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .beat        (in_data),
        .image_width (image_width_reg),
        .item        (front_item)
    );

    dewf_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_item (front_item),
        .pop       (fifo_pop),
        .pop_item  (fifo_item),
        .not_empty (fifo_not_empty),
        .full      (fifo_full)
    );

    dewf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .item_valid (fifo_not_empty),
        .item       (fifo_item),
        .pop        (fifo_pop),
        .direction  (direction_reg),
        .diff_valid (diff_valid),
        .diff       (diff)
    );

    dewf_exp u_exp (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .diff_valid (diff_valid),
        .diff       (diff),
        .inv_gamma  (inv_gamma_reg),
        .out_valid  (out_valid),
        .out_data   (out_data)
    );

endmodule

// ===== hdl/dewf_front.sv =====
// Front end: tracks column, row and flush counts and classifies each input beat.
module dewf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  dewf_pkg::in_beat_t  beat,
    input  logic [11:0]         image_width,
    output dewf_pkg::item_t     item
);

    logic [dewf_pkg::X_W-1:0]     cc_reg, cc_next;
    logic [1:0]                   rp_reg, rp_next;
    logic [dewf_pkg::FLUSH_W-1:0] fc_reg, fc_next;

    logic [dewf_pkg::W_W-1:0] w;
    logic                     wrap;
    logic [dewf_pkg::X_W-1:0] x;
    logic [1:0]               rp_a;
    logic [dewf_pkg::FLUSH_W-1:0] fc_a;
    logic                     last;
    logic                     x_end;

    always_comb
    begin
        if (image_width == 12'd0)
        begin
            w = dewf_pkg::W_W'(1);
        end
        else if (32'(image_width) > dewf_pkg::MAX_WIDTH)
        begin
            w = dewf_pkg::W_W'(dewf_pkg::MAX_WIDTH);
        end
        else
        begin
            w = dewf_pkg::W_W'(image_width);
        end

        // width lowered under a running row: start a new row
        wrap = (32'(cc_reg) >= 32'(w));
        x    = wrap ? '0 : cc_reg;
        rp_a = (wrap && rp_reg != 2'd3) ? rp_reg + 2'd1 : rp_reg;

        fc_a = fc_reg;
        if (beat.flush && 32'(fc_reg) != dewf_pkg::FLUSH_MAX)
        begin
            fc_a = fc_reg + 1'b1;
        end
        last  = beat.flush && (32'(fc_a) >= 32'(w) + 32'd1);
        x_end = (32'(x) + 32'd1 >= 32'(w));

        item.pixel      = beat.pixel;
        item.flush      = beat.flush;
        item.x          = x;
        item.row_phase  = rp_a;
        item.emit_wrap  = (x == '0) && (rp_a >= 2'd2);
        item.emit_main  = (x != '0) && (rp_a >= 2'd1);
        item.w_one      = (w == dewf_pkg::W_W'(1));
        item.x_one      = (x == dewf_pkg::X_W'(1));
        item.last_flush = last;

        cc_next = cc_reg;
        rp_next = rp_reg;
        fc_next = fc_reg;
        if (accept)
        begin
            if (last)
            begin
                cc_next = '0;
                rp_next = '0;
                fc_next = '0;
            end
            else
            begin
                fc_next = fc_a;
                if (x_end)
                begin
                    cc_next = '0;
                    rp_next = (rp_a != 2'd3) ? rp_a + 2'd1 : rp_a;
                end
                else
                begin
                    cc_next = x + 1'b1;
                    rp_next = rp_a;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg <= '0;
            rp_reg <= '0;
            fc_reg <= '0;
        end
        else
        begin
            cc_reg <= cc_next;
            rp_reg <= rp_next;
            fc_reg <= fc_next;
        end
    end

endmodule

// ===== hdl/dewf_fifo.sv =====
// Short queue of classified items between the front and the back.
module dewf_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dewf_pkg::item_t push_item,
    input  logic            pop,
    output dewf_pkg::item_t pop_item,
    output logic            not_empty,
    output logic            full
);

    dewf_pkg::item_t                store_reg [dewf_pkg::FIFO_DEPTH];
    logic [dewf_pkg::FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [dewf_pkg::FIFO_AW:0]     count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (32'(count_reg) == dewf_pkg::FIFO_DEPTH);
    assign pop_item  = store_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/dewf_back.sv =====
// Back end: line buffers, 3x3 window and the directional second difference.
module dewf_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            item_valid,
    input  dewf_pkg::item_t item,
    output logic            pop,
    input  logic [1:0]      direction,
    output logic            diff_valid,
    output dewf_pkg::diff_t diff
);

    logic [15:0] upper_mem  [dewf_pkg::MAX_WIDTH];
    logic [15:0] middle_mem [dewf_pkg::MAX_WIDTH];

    logic            a_valid_reg;
    dewf_pkg::item_t a_item_reg;
    logic [15:0]     up_rd_reg, mid_rd_reg;
    logic            byp_reg;
    logic [15:0]     byp_up_reg, byp_mid_reg;

    // window columns: older (1) and newer (2); rows top, middle, bottom
    logic [15:0] win1_reg [3];
    logic [15:0] win2_reg [3];

    logic            d_valid_reg;
    dewf_pkg::diff_t diff_reg;

    logic [15:0] up_rd, mid_rd, pix_b, top_b, mid_b;
    logic [15:0] new_col [3];
    logic [15:0] col_l [3];
    logic [15:0] col_r [3];
    logic        sel_l, sel_r;
    logic [15:0] prev, next, centre;
    logic signed [dewf_pkg::DIFF_W-1:0] d;

    assign pop        = adv && item_valid;
    assign diff_valid = d_valid_reg;
    assign diff       = diff_reg;

    always_comb
    begin
        up_rd  = byp_reg ? byp_up_reg  : up_rd_reg;
        mid_rd = byp_reg ? byp_mid_reg : mid_rd_reg;

        pix_b = a_item_reg.pixel;
        if (a_item_reg.flush)
        begin
            pix_b = (a_item_reg.row_phase >= 2'd1) ? mid_rd : 16'd0;
        end
        if (a_item_reg.row_phase == 2'd0)
        begin
            top_b = pix_b;
            mid_b = pix_b;
        end
        else
        begin
            mid_b = mid_rd;
            top_b = (a_item_reg.row_phase >= 2'd2) ? up_rd : mid_rd;
        end
        new_col[0] = top_b;
        new_col[1] = mid_b;
        new_col[2] = pix_b;

        sel_l = a_item_reg.emit_wrap ? a_item_reg.w_one : a_item_reg.x_one;
        sel_r = a_item_reg.emit_main;
        for (int k = 0; k < 3; k++)
        begin
            col_l[k] = sel_l ? win2_reg[k] : win1_reg[k];
            col_r[k] = sel_r ? new_col[k]  : win2_reg[k];
        end

        centre = win2_reg[1];
        case (dewf_pkg::direction_t'(direction))
            dewf_pkg::DIR_HORIZONTAL:
            begin
                prev = col_l[1];
                next = col_r[1];
            end
            dewf_pkg::DIR_VERTICAL:
            begin
                prev = win2_reg[0];
                next = win2_reg[2];
            end
            dewf_pkg::DIR_MAIN_DIAG:
            begin
                prev = col_l[0];
                next = col_r[2];
            end
            dewf_pkg::DIR_ANTI_DIAG:
            begin
                prev = col_r[0];
                next = col_l[2];
            end
            default:
            begin
                prev = col_l[1];
                next = col_r[1];
            end
        endcase

        d = $signed({3'b000, prev}) + $signed({3'b000, next})
            - $signed({2'b00, centre, 1'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            byp_reg     <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                win1_reg[k] <= '0;
                win2_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            a_valid_reg <= pop;
            d_valid_reg <= a_valid_reg && (a_item_reg.emit_wrap || a_item_reg.emit_main);
            // read and write of one address at the same edge: forward the write
            byp_reg     <= a_valid_reg && pop && (a_item_reg.x == item.x);
            if (a_valid_reg)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win1_reg[k] <= a_item_reg.last_flush ? 16'd0 : win2_reg[k];
                    win2_reg[k] <= a_item_reg.last_flush ? 16'd0 : new_col[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg            <= item;
            byp_up_reg            <= mid_b;
            byp_mid_reg           <= pix_b;
            diff_reg.d            <= d;
            diff_reg.end_of_row   <= a_item_reg.emit_wrap;
            diff_reg.end_of_frame <= a_item_reg.last_flush;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (a_valid_reg)
            begin
                upper_mem[a_item_reg.x]  <= mid_b;
                middle_mem[a_item_reg.x] <= pix_b;
            end
            up_rd_reg  <= upper_mem[item.x];
            mid_rd_reg <= middle_mem[item.x];
        end
    end

endmodule

// ===== hdl/dewf_exp.sv =====
// Exponential weight pipeline: scale, clamp, base-2 split, table lookup, shift.
module dewf_exp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                diff_valid,
    input  dewf_pkg::diff_t     diff,
    input  logic [15:0]         inv_gamma,
    output logic                out_valid,
    output dewf_pkg::out_beat_t out_data
);

    logic [31:0] pow2_tab [dewf_pkg::EXP_TABLE_ENTRIES + 1];

    for (genvar g = 0; g <= dewf_pkg::EXP_TABLE_ENTRIES; g++)
    begin : g_tab
        localparam logic [31:0] RAW = dewf_pkg::pow2_raw(g);
        localparam logic [31:0] PRV = (g == 0) ? RAW : dewf_pkg::pow2_raw(g - 1);
        assign pow2_tab[g] = (RAW < PRV) ? PRV : RAW;
    end

    logic [4:0] v_reg;
    logic [1:0] flag1_reg, flag2_reg, flag3_reg, flag4_reg, flag5_reg;

    logic signed [dewf_pkg::P_W-1:0]  p_reg;
    logic signed [dewf_pkg::PC_W-1:0] pc_reg;
    logic                             sat2_reg, zero2_reg;
    logic [36:0]                      u_reg;
    logic                             sat3_reg, zero3_reg;
    logic [31:0]                      t0_reg, t1_reg;
    logic [15:0]                      rem_reg;
    logic [4:0]                       n4_reg, n5_reg;
    logic                             sat4_reg, zero4_reg, sat5_reg, zero5_reg;
    logic [31:0]                      val_reg;

    logic signed [dewf_pkg::P_W-1:0] prod;
    logic signed [dewf_pkg::U_W-1:0] u;
    logic [dewf_pkg::IDX_W-1:0]      idx;
    logic [dewf_pkg::TAB_W-1:0]      idx0, idx1;
    logic [47:0]                     interp;
    logic [56:0]                     shifted;
    logic [24:0]                     r;
    logic [23:0]                     weight;
    logic                            out_valid_reg;
    dewf_pkg::out_beat_t             out_data_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        prod = $signed(diff.d) * $signed({1'b0, inv_gamma});
        u    = $signed(pc_reg) * $signed({1'b0, 25'(dewf_pkg::LOG2E_Q24)})
               + $signed(dewf_pkg::U_W'(dewf_pkg::U_OFFSET));
        idx  = u_reg[31 -: dewf_pkg::IDX_W];
        idx0 = dewf_pkg::TAB_W'(idx);
        idx1 = idx0 + 1'b1;
        interp  = (48'(t1_reg - t0_reg) * 48'(rem_reg)) >> 16;
        shifted = (57'(val_reg) << n5_reg) + (57'd1 << 31);
        r       = shifted[56:32];
        // the clamp flags come first: the shifted value is meaningless under them
        if (sat5_reg)
        begin
            weight = 24'hFF_FFFF;
        end
        else if (zero5_reg)
        begin
            weight = 24'd0;
        end
        else if (r > 25'hFF_FFFF)
        begin
            weight = 24'hFF_FFFF;
        end
        else
        begin
            weight = r[23:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg         <= {v_reg[3:0], diff_valid};
            out_valid_reg <= v_reg[4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flag1_reg <= {diff.end_of_row, diff.end_of_frame};
            p_reg     <= -prod;

            flag2_reg <= flag1_reg;
            sat2_reg  <= (p_reg >= dewf_pkg::P_W'(dewf_pkg::SAT_P));
            zero2_reg <= (p_reg <= dewf_pkg::P_W'(dewf_pkg::ZERO_P));
            pc_reg    <= p_reg[dewf_pkg::PC_W-1:0];

            flag3_reg <= flag2_reg;
            sat3_reg  <= sat2_reg;
            zero3_reg <= zero2_reg;
            u_reg     <= u[36:0];

            flag4_reg <= flag3_reg;
            sat4_reg  <= sat3_reg;
            zero4_reg <= zero3_reg;
            n4_reg    <= u_reg[36:32];
            rem_reg   <= u_reg[31 - dewf_pkg::IDX_W -: 16];
            t0_reg    <= pow2_tab[idx0];
            t1_reg    <= pow2_tab[idx1];

            flag5_reg <= flag4_reg;
            sat5_reg  <= sat4_reg;
            zero5_reg <= zero4_reg;
            n5_reg    <= n4_reg;
            val_reg   <= t0_reg + interp[31:0];

            out_data_reg.weight       <= weight;
            out_data_reg.end_of_row   <= flag5_reg[1];
            out_data_reg.end_of_frame <= flag5_reg[0];
        end
    end

endmodule

// ===== hdl/dewf_checker.sv =====
// Port-level checker for the directional edge weight filter, bound to the top level.
module dewf_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input dewf_pkg::out_beat_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("output beat changed while stalled");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid && !in_stall)
        else $error("beat or stall shown during reset");

    a_no_early_out: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid ##1 !out_valid)
        else $error("output beat without input after reset");

endmodule

bind directional_edge_weight_filter dewf_checker u_dewf_checker (.*);

// ===== test/directional_edge_weight_filter_tb.sv =====
// Self-checking testbench for the directional edge weight filter.
module directional_edge_weight_filter_tb;

    localparam int          CLK_HALF   = 10;
    localparam int          TAIL_WAIT  = 24;    // pipeline plus queue, with margin
    localparam int          IDLE_LIMIT = 2000;  // cycles with no beat before giving up
    localparam int          RAND_BEATS = 800;
    localparam longint      LOG2E      = 24204406;
    localparam longint      LN2        = 744261118;
    localparam longint      ONE        = 64'sd1 << 32;
    localparam logic [23:0] SAT        = 24'hFFFFFF;
    localparam logic [23:0] UNITY      = 24'd4096;  // exp(0) in Q12.12

    typedef enum logic { ROW_BEAT, ROW_REG } row_kind_t;

    typedef struct {
        row_kind_t            kind;
        dewf_pkg::reg_index_t index;
        logic [15:0]          value;  // pixel for a beat, data for a register write
        logic                 flush;
        int                   typed;  // expected weight, or -1 to take the prediction
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    dewf_pkg::in_beat_t  in_data;
    logic                out_valid;
    logic                out_stall;
    dewf_pkg::out_beat_t out_data;
    logic                cfg_write;
    logic [1:0]          cfg_index;
    logic [15:0]         cfg_data;

    directional_edge_weight_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // Shadow of the block: registers, line stores, 3x3 window and counters.
    logic [1:0]  sh_direction;
    logic [15:0] sh_inv_gamma;
    logic [11:0] sh_width;
    logic [15:0] upper_row [dewf_pkg::MAX_WIDTH];
    logic [15:0] middle_row [dewf_pkg::MAX_WIDTH];
    logic [15:0] win [3][3];   // [top, middle, bottom][left, centre, right]
    int          column;
    int          rows_begun;
    int          flushes_seen;
    longint unsigned pow2_q30 [dewf_pkg::EXP_TABLE_ENTRIES + 1];

    dewf_pkg::out_beat_t weights_due [$];
    stim_row_t           directed [$];
    int          mismatches;
    int          quiet_cycles;
    bit          calm;         // when set, neither side inserts idle cycles
    int          beats_sent;

    // 2^(i/N) in Q2.30 by a 21-term Taylor series, kept monotonic.
    task automatic build_pow2();
        longint unsigned x;
        longint unsigned term;
        longint unsigned sum;
        for (int i = 0; i <= dewf_pkg::EXP_TABLE_ENTRIES; i++)
        begin
            x = (longint'(i) * LN2) / dewf_pkg::EXP_TABLE_ENTRIES;
            term = 64'd1 << 30;
            sum = term;
            for (int k = 1; k <= 20; k++)
            begin
                term = (term * x) / (longint'(k) << 30);
                sum = sum + term;
            end
            pow2_q30[i] = {32'd0, sum[31:0]};
            if (i > 0 && pow2_q30[i] < pow2_q30[i - 1])
                pow2_q30[i] = pow2_q30[i - 1];
        end
    endtask

    function automatic logic [23:0] exp_weight(longint d);
        longint q;
        longint unsigned u;
        longint unsigned frac;
        longint unsigned pos;
        longint unsigned rem;
        longint unsigned v;
        longint unsigned r;
        int n;
        int idx;
        q = -(d * longint'(sh_inv_gamma) * LOG2E);
        if (q >= 12 * ONE)
            return SAT;
        if (q < -14 * ONE)
            return 24'd0;
        u = q + 14 * ONE;
        n = int'(u >> 32);
        frac = u & 64'hFFFF_FFFF;
        pos = frac * dewf_pkg::EXP_TABLE_ENTRIES;
        idx = int'(pos >> 32);
        rem = (pos & 64'hFFFF_FFFF) >> 16;
        v = pow2_q30[idx] + (((pow2_q30[idx + 1] - pow2_q30[idx]) * rem) >> 16);
        r = ((v << n) + (64'd1 << 31)) >> 32;
        return (r > 64'(SAT)) ? SAT : r[23:0];
    endfunction

    // Second difference through the window column c, with l/r the neighbors.
    function automatic dewf_pkg::out_beat_t stencil(int l, int c, int r, logic eor,
                                                    logic eof);
        longint prev;
        longint next;
        dewf_pkg::out_beat_t res;
        case (dewf_pkg::direction_t'(sh_direction))
            dewf_pkg::DIR_HORIZONTAL: begin prev = win[1][l]; next = win[1][r]; end
            dewf_pkg::DIR_VERTICAL:   begin prev = win[0][c]; next = win[2][c]; end
            dewf_pkg::DIR_MAIN_DIAG:  begin prev = win[0][l]; next = win[2][r]; end
            default:                  begin prev = win[0][r]; next = win[2][l]; end
        endcase
        res.weight = exp_weight(prev + next - 2 * longint'(win[1][c]));
        res.end_of_row = eor;
        res.end_of_frame = eof;
        return res;
    endfunction

    // Advance the shadow by one beat; return 1 when that beat releases a weight.
    function automatic bit advance_filter(logic [15:0] pix_in, logic fl,
                                          output dewf_pkg::out_beat_t res);
        int w;
        int x;
        logic [15:0] pix;
        logic [15:0] top;
        logic [15:0] mid;
        bit frame_done;
        bit have;
        w = sh_width;
        pix = pix_in;
        frame_done = 0;
        have = 0;
        if (w < 1)
            w = 1;
        if (w > dewf_pkg::MAX_WIDTH)
            w = dewf_pkg::MAX_WIDTH;
        x = column;
        // width lowered under a running row: wrap to a new row
        if (x >= w)
        begin
            x = 0;
            if (rows_begun < 3)
                rows_begun++;
        end
        if (fl)
        begin
            if (flushes_seen < dewf_pkg::FLUSH_MAX)
                flushes_seen++;
            frame_done = (flushes_seen >= w + 1);
            pix = (rows_begun >= 1) ? middle_row[x] : 16'd0;
        end
        // last pixel of the row two back comes out of the window before the shift
        if (x == 0 && rows_begun >= 2)
        begin
            res = stencil((w == 1) ? 2 : 1, 2, 2, 1'b1, frame_done);
            have = 1;
        end
        if (rows_begun == 0)
        begin
            top = pix;
            mid = pix;
        end
        else
        begin
            mid = middle_row[x];
            top = (rows_begun >= 2) ? upper_row[x] : mid;
        end
        for (int k = 0; k < 3; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = pix;
        upper_row[x] = mid;
        middle_row[x] = pix;
        if (x >= 1 && rows_begun >= 1)
        begin
            res = stencil((x == 1) ? 1 : 0, 1, 2, 1'b0, frame_done);
            have = 1;
        end
        if (frame_done)
        begin
            column = 0;
            rows_begun = 0;
            flushes_seen = 0;
            for (int a = 0; a < 3; a++)
                for (int b = 0; b < 3; b++)
                    win[a][b] = '0;
        end
        else if (x + 1 >= w)
        begin
            column = 0;
            if (rows_begun < 3)
                rows_begun++;
        end
        else
            column = x + 1;
        return have;
    endfunction

    // Offer one beat, hold it until taken, then queue what it releases.
    task automatic send_beat(logic [15:0] pix, logic fl, int typed);
        int gap;
        dewf_pkg::out_beat_t res;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.pixel <= pix;
        in_data.flush <= fl;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
        if (advance_filter(pix, fl, res))
        begin
            if (typed >= 0)
                res.weight = typed[23:0];
            weights_due.push_back(res);
        end
    endtask

    // Drain, let the pipeline settle, then write one register.
    task automatic write_reg(dewf_pkg::reg_index_t idx, logic [15:0] value);
        in_valid <= 1'b0;
        wait (weights_due.size() == 0);
        repeat (TAIL_WAIT) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            dewf_pkg::REG_DIRECTION:   sh_direction = value[1:0];
            dewf_pkg::REG_INV_GAMMA:   sh_inv_gamma = value;
            dewf_pkg::REG_IMAGE_WIDTH: sh_width = value[11:0];
            default: ;
        endcase
    endtask

    task automatic add_beat(logic [15:0] pix, logic fl, int typed);
        directed.push_back('{ROW_BEAT, dewf_pkg::REG_DIRECTION, pix, fl, typed});
    endtask

    task automatic add_reg(dewf_pkg::reg_index_t idx, logic [15:0] value);
        directed.push_back('{ROW_REG, idx, value, 1'b0, -1});
    endtask

    function automatic logic [15:0] pick_gamma();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(1, 64));
        endcase
    endfunction

    // Sink: draw a stall per weight and compare each taken beat in order.
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else if (out_valid && !out_stall)
        begin
            if (weights_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected weight beat: weight %h eor %b eof %b",
                             out_data.weight, out_data.end_of_row, out_data.end_of_frame);
            end
            else
            begin
                dewf_pkg::out_beat_t want;
                want = weights_due.pop_front();
                if (out_data.weight !== want.weight ||
                    out_data.end_of_row !== want.end_of_row ||
                    out_data.end_of_frame !== want.end_of_frame)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("weight mismatch: expected %h/%b/%b, got %h/%b/%b",
                                 want.weight, want.end_of_row, want.end_of_frame,
                                 out_data.weight, out_data.end_of_row,
                                 out_data.end_of_frame);
                end
            end
            stall_left = calm ? 0 : $urandom_range(0, 3);
            out_stall <= (stall_left != 0);
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            if (stall_left == 0)
                out_stall <= 1'b0;
        end
    end

    // Watchdog: count cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("directional_edge_weight_filter_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        int w;
        int rows;
        int base;
        int spread;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_write = 1'b0;
        cfg_index = dewf_pkg::REG_DIRECTION;
        cfg_data = '0;
        mismatches = 0;
        quiet_cycles = 0;
        beats_sent = 0;
        calm = 0;
        sh_direction = dewf_pkg::DIRECTION_RESET;
        sh_inv_gamma = dewf_pkg::INV_GAMMA_RESET;
        sh_width = dewf_pkg::IMAGE_WIDTH_RESET;
        column = 0;
        rows_begun = 0;
        flushes_seen = 0;
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                win[a][b] = '0;
        build_pow2();

        // Flat frame: every second difference is zero, so every weight is 1.0.
        add_reg(dewf_pkg::REG_IMAGE_WIDTH, 16'd3);
        for (int i = 0; i < 9; i++)
            add_beat(16'h8000, 1'b0, UNITY);
        for (int i = 0; i < 4; i++)
            add_beat(16'h0, 1'b1, UNITY);
        // Zero gain: any image gives 1.0.
        add_reg(dewf_pkg::REG_INV_GAMMA, 16'd0);
        add_reg(dewf_pkg::REG_DIRECTION, dewf_pkg::DIR_VERTICAL);
        add_beat(16'hFFFF, 1'b0, -1);
        add_beat(16'h0000, 1'b0, -1);
        add_beat(16'h5A5A, 1'b0, UNITY);
        add_beat(16'hA5A5, 1'b0, UNITY);
        add_beat(16'hFFFF, 1'b0, UNITY);
        add_beat(16'h0001, 1'b0, UNITY);
        for (int i = 0; i < 4; i++)
            add_beat(16'h0, 1'b1, UNITY);
        // Checkerboard at full gain, anti-diagonal: saturation and flush to zero,
        // with an ordinary pixel slipped in among the flush beats.
        add_reg(dewf_pkg::REG_INV_GAMMA, 16'hFFFF);
        add_reg(dewf_pkg::REG_DIRECTION, dewf_pkg::DIR_ANTI_DIAG);
        for (int i = 0; i < 9; i++)
            add_beat((i % 2) ? 16'hFFFF : 16'h0000, 1'b0, -1);
        add_beat(16'h0, 1'b1, -1);
        add_beat(16'h1234, 1'b0, -1);
        for (int i = 0; i < 3; i++)
            add_beat(16'h0, 1'b1, -1);
        // Flush before any row is complete, then width zero acting as one.
        add_reg(dewf_pkg::REG_DIRECTION, dewf_pkg::DIR_MAIN_DIAG);
        for (int i = 0; i < 4; i++)
            add_beat(16'hFFFF, 1'b1, -1);
        add_reg(dewf_pkg::REG_IMAGE_WIDTH, 16'd0);
        add_beat(16'h0005, 1'b0, -1);
        add_beat(16'hFFFF, 1'b0, -1);
        add_beat(16'h0, 1'b1, -1);
        add_beat(16'h0, 1'b1, -1);
        // Width lowered under a running row: the row wraps early.
        add_reg(dewf_pkg::REG_INV_GAMMA, 16'd8);
        add_reg(dewf_pkg::REG_DIRECTION, dewf_pkg::DIR_HORIZONTAL);
        add_reg(dewf_pkg::REG_IMAGE_WIDTH, 16'd5);
        for (int i = 0; i < 8; i++)
            add_beat(16'(1000 + 37 * i), 1'b0, -1);
        add_reg(dewf_pkg::REG_IMAGE_WIDTH, 16'd3);
        add_beat(16'd900, 1'b0, -1);
        for (int i = 0; i < 4; i++)
            add_beat(16'h0, 1'b1, -1);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_REG)
                write_reg(directed[i].index, directed[i].value);
            else
                send_beat(directed[i].value, directed[i].flush, directed[i].typed);
        end

        // Random frames: mostly smooth images with random content, some noise beats.
        while (beats_sent < RAND_BEATS)
        begin
            calm = ($urandom_range(0, 3) == 0);
            write_reg(dewf_pkg::REG_DIRECTION, 16'($urandom_range(0, 3)));
            write_reg(dewf_pkg::REG_INV_GAMMA, pick_gamma());
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            write_reg(dewf_pkg::REG_IMAGE_WIDTH, 16'(w));
            if (w < 1)
                w = 1;
            rows = $urandom_range(1, 5);
            base = $urandom;
            base = base & 16'hFFFF;
            spread = ($urandom_range(0, 4) == 0) ? 65535 : $urandom_range(1, 63);
            for (int i = 0; i < rows * w; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_beat(16'($urandom), 1'b1, -1);
                else
                    send_beat(16'((base + $urandom_range(0, spread)) & 16'hFFFF), 1'b0, -1);
            end
            // close the frame; the odd ordinary pixel may sit among the padding
            while (flushes_seen != 0 || column != 0 || rows_begun != 0)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_beat(16'($urandom), 1'b0, -1);
                else
                    send_beat(16'($urandom), 1'b1, -1);
            end
        end

        calm = 0;
        in_valid <= 1'b0;
        wait (weights_due.size() == 0);
        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("directional_edge_weight_filter_tb: done, clean");
        else
            $display("directional_edge_weight_filter_tb: done, errors");
        $finish;
    end

endmodule
